[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[rtl/rsfd_pkg.sv]
// ----------------------------------------------------------------------------
// rsfd_pkg
// shared widths, constants and types of the run-length frame decoder
// ----------------------------------------------------------------------------
package rsfd_pkg;

    localparam int PIXEL_W = 8;
    localparam int LEN_W   = 17;
    localparam int COUNT_W = 7;

    // bit 7 of a command byte selects a repeat run
    localparam int REPEAT_FLAG_BIT = 7;

    localparam int unsigned MAX_FRAME_PIXELS_DEF = 65536;

    localparam int QUEUE_DEPTH = 4;

    // work for the back end, one entry per byte that causes results
    typedef struct packed {
        logic               run_vld;
        logic [PIXEL_W-1:0] run_value;
        logic [LEN_W-1:0]   run_len;
        logic               close_vld;
        logic [LEN_W-1:0]   close_len;
    } entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

endpackage

[rtl/rsfd_in_if.sv]
// ----------------------------------------------------------------------------
// rsfd_in_if
// compressed byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface rsfd_in_if;
    logic                        valid;
    logic                        ready;
    logic [rsfd_pkg::PIXEL_W-1:0] data_byte;
    logic                        stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

[rtl/rsfd_out_if.sv]
// ----------------------------------------------------------------------------
// rsfd_out_if
// decoded run channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface rsfd_out_if;
    logic                         valid;
    logic                         ready;
    logic [rsfd_pkg::PIXEL_W-1:0] pix_index;
    logic [rsfd_pkg::LEN_W-1:0]   run_length;
    logic                         is_padding;
    logic                         frame_end;
    logic                         item_last;

    modport source (output valid, output pix_index, output run_length, output is_padding,
                    output frame_end, output item_last, input ready);
    modport sink   (input valid, input pix_index, input run_length, input is_padding,
                    input frame_end, input item_last, output ready);
endinterface

[rtl/rsfd_front.sv]
// ----------------------------------------------------------------------------
// rsfd_front
// command parser: tracks the decode phase and pixels owed, emits queue entries
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsfd_front #(
    parameter int unsigned MAX_FRAME_PIXELS = rsfd_pkg::MAX_FRAME_PIXELS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rsfd_pkg::LEN_W-1:0] cfg_wr_data,
    rsfd_in_if.sink                    stream,
    input  rsfd_pkg::q_stat_t          q_stat,
    output logic                       push,
    output rsfd_pkg::entry_t           push_entry
);

    localparam logic [1:0] PH_CMD     = 2'd0;
    localparam logic [1:0] PH_VALUE   = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    localparam int unsigned LenMax = (1 << rsfd_pkg::LEN_W) - 1;
    localparam int unsigned ClipVal = (MAX_FRAME_PIXELS > LenMax) ? LenMax : MAX_FRAME_PIXELS;

    logic [rsfd_pkg::LEN_W-1:0]   frame_pixels_reg;
    logic [1:0]                   phase_reg, phase_next;
    logic [rsfd_pkg::COUNT_W-1:0] literal_left_reg, literal_left_next;
    logic [rsfd_pkg::COUNT_W-1:0] repeat_count_reg, repeat_count_next;
    logic [rsfd_pkg::LEN_W-1:0]   pixels_owed_reg, pixels_owed_next;
    logic                         frame_open_reg, frame_open_next;

    logic                         accept;
    logic [rsfd_pkg::LEN_W-1:0]   fp_sat;
    logic [rsfd_pkg::LEN_W-1:0]   run_len;
    logic                         run_vld;

    assign stream.ready = !q_stat.full;
    assign accept       = stream.valid && stream.ready;

    // frame size is sampled when the frame opens, saturated to the supported maximum
    always_comb
    begin
        if (32'(frame_pixels_reg) > 32'(MAX_FRAME_PIXELS))
            fp_sat = rsfd_pkg::LEN_W'(ClipVal);
        else
            fp_sat = frame_pixels_reg;
    end

    always_comb
    begin
        phase_next        = phase_reg;
        literal_left_next = literal_left_reg;
        repeat_count_next = repeat_count_reg;
        pixels_owed_next  = pixels_owed_reg;
        frame_open_next   = 1'b1;
        run_vld           = 1'b0;
        run_len           = '0;

        if (!frame_open_reg)
        begin
            pixels_owed_next  = fp_sat;
            literal_left_next = '0;
            repeat_count_next = '0;
            phase_next        = (fp_sat == '0) ? PH_DONE : PH_CMD;
        end

        case (phase_next)
            PH_CMD:
            begin
                // a command carried on the last byte is dropped
                if (!stream.stream_end)
                begin
                    if (stream.data_byte[rsfd_pkg::REPEAT_FLAG_BIT])
                    begin
                        repeat_count_next = stream.data_byte[rsfd_pkg::COUNT_W-1:0];
                        phase_next        = PH_VALUE;
                    end
                    else
                    begin
                        literal_left_next = stream.data_byte[rsfd_pkg::COUNT_W-1:0];
                        phase_next = (stream.data_byte[rsfd_pkg::COUNT_W-1:0] != '0) ?
                                     PH_LITERAL : PH_CMD;
                    end
                end
            end
            PH_VALUE:
            begin
                // repeat count of zero is the end marker
                if (repeat_count_next == '0)
                    phase_next = PH_DONE;
                else
                begin
                    run_vld = 1'b1;
                    if (rsfd_pkg::LEN_W'(repeat_count_next) > pixels_owed_next)
                        run_len = pixels_owed_next;
                    else
                        run_len = rsfd_pkg::LEN_W'(repeat_count_next);
                    pixels_owed_next  = pixels_owed_next - run_len;
                    repeat_count_next = '0;
                    phase_next = (pixels_owed_next == '0) ? PH_DONE : PH_CMD;
                end
            end
            PH_LITERAL:
            begin
                run_vld           = 1'b1;
                run_len           = rsfd_pkg::LEN_W'(1);
                pixels_owed_next  = pixels_owed_next - rsfd_pkg::LEN_W'(1);
                literal_left_next = literal_left_next - rsfd_pkg::COUNT_W'(1);
                if (pixels_owed_next == '0)
                    phase_next = PH_DONE;
                else
                    phase_next = (literal_left_next != '0) ? PH_LITERAL : PH_CMD;
            end
            default:
            begin
            end
        endcase

        push_entry.run_vld   = run_vld;
        push_entry.run_value = stream.data_byte;
        push_entry.run_len   = run_len;
        push_entry.close_vld = stream.stream_end;
        push_entry.close_len = pixels_owed_next;

        if (stream.stream_end)
        begin
            pixels_owed_next  = '0;
            frame_open_next   = 1'b0;
            literal_left_next = '0;
            repeat_count_next = '0;
            phase_next        = PH_CMD;
        end
    end

    assign push = accept && (run_vld || stream.stream_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= '0;
            phase_reg        <= PH_CMD;
            literal_left_reg <= '0;
            repeat_count_reg <= '0;
            pixels_owed_reg  <= '0;
            frame_open_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                frame_pixels_reg <= cfg_wr_data;
            if (accept)
            begin
                phase_reg        <= phase_next;
                literal_left_reg <= literal_left_next;
                repeat_count_reg <= repeat_count_next;
                pixels_owed_reg  <= pixels_owed_next;
                frame_open_reg   <= frame_open_next;
            end
        end
    end

    `ASSERT_PROP(a_close_ends_frame, clk, rst_n,
        (accept && stream.stream_end) |=> !frame_open_reg, "frame still open after last byte")
    `ASSERT_NEVER(a_run_nonempty, clk, rst_n,
        push && push_entry.run_vld && push_entry.run_len == '0, "empty data run pushed")
    `ASSERT_NEVER(a_owed_bounded, clk, rst_n,
        frame_open_reg && 32'(pixels_owed_reg) > 32'(MAX_FRAME_PIXELS),
        "pixels owed above frame maximum")

endmodule

[rtl/rsfd_queue.sv]
// ----------------------------------------------------------------------------
// rsfd_queue
// short fifo of decoded work between the parser and the run emitter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsfd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rsfd_pkg::entry_t  push_entry,
    input  logic              pop,
    output rsfd_pkg::entry_t  head,
    output rsfd_pkg::q_stat_t q_stat
);

    localparam int Depth = rsfd_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    rsfd_pkg::entry_t  slot_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full      = (count_reg == CntW'(Depth));
    assign q_stat.not_empty = (count_reg != '0);
    assign head             = slot_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && q_stat.not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CntW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    `ASSERT_NEVER(a_no_push_full, clk, rst_n, push && q_stat.full, "push into full queue")
    `ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && !q_stat.not_empty, "pop from empty queue")
    `ASSERT_NEVER(a_count_bounded, clk, rst_n, count_reg > CntW'(Depth), "queue count above depth")

endmodule

[rtl/rsfd_back.sv]
// ----------------------------------------------------------------------------
// rsfd_back
// run emitter: turns queue entries into data and closing runs on the output
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsfd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rsfd_pkg::q_stat_t q_stat,
    input  rsfd_pkg::entry_t  head,
    output logic              pop,
    rsfd_out_if.source        runs
);

    logic                         out_vld_reg, out_vld_next;
    logic                         sub_reg, sub_next;
    logic [rsfd_pkg::PIXEL_W-1:0] pixel_reg;
    logic [rsfd_pkg::LEN_W-1:0]   len_reg;
    logic                         pad_reg;
    logic                         fend_reg;
    logic                         last_reg;

    logic                         load;
    logic                         take;
    logic                         emit_run;

    // output register frees when empty or being taken
    assign load     = !out_vld_reg || runs.ready;
    assign take     = load && q_stat.not_empty;
    // sub_reg marks that the data run of the head entry has already gone out
    assign emit_run = head.run_vld && !sub_reg;
    assign pop      = take && !(emit_run && head.close_vld);

    always_comb
    begin
        sub_next     = sub_reg;
        out_vld_next = out_vld_reg;
        if (take)
        begin
            sub_next     = emit_run && head.close_vld;
            out_vld_next = 1'b1;
        end
        else if (load)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            sub_reg     <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            sub_reg     <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (emit_run)
            begin
                pixel_reg <= head.run_value;
                len_reg   <= head.run_len;
                pad_reg   <= 1'b0;
                fend_reg  <= 1'b0;
                last_reg  <= !head.close_vld;
            end
            else
            begin
                pixel_reg <= '0;
                len_reg   <= head.close_len;
                pad_reg   <= (head.close_len != '0);
                fend_reg  <= 1'b1;
                last_reg  <= 1'b1;
            end
        end
    end

    assign runs.valid      = out_vld_reg;
    assign runs.pix_index  = pixel_reg;
    assign runs.run_length = len_reg;
    assign runs.is_padding = pad_reg;
    assign runs.frame_end  = fend_reg;
    assign runs.item_last  = last_reg;

    `ASSERT_PROP(a_split_needs_close, clk, rst_n,
        sub_reg |-> (q_stat.not_empty && head.close_vld && head.run_vld),
        "split entry without closing run")
    `ASSERT_PROP(a_frame_end_is_last, clk, rst_n,
        (out_vld_reg && fend_reg) |-> last_reg, "closing run not marked last")
    `ASSERT_PROP(a_out_held, clk, rst_n,
        (out_vld_reg && !runs.ready) |=> out_vld_reg, "output item dropped while stalled")

endmodule

[rtl/rle_sprite_frame_decoder.sv]
// ----------------------------------------------------------------------------
// rle_sprite_frame_decoder
// run-length frame decoder producing runs of 8-bit pixel indices
// ----------------------------------------------------------------------------
// usage
//   stream carries compressed bytes (data_byte, stream_end marks the last byte
//   of a frame); runs carries results (pix_index, run_length, is_padding,
//   frame_end, item_last). both use valid/ready, an item moves when both high.
//   cfg_wr_en/cfg_wr_data write the frame size, taken when the next frame opens.
// timing
//   a byte's runs go through the work queue and then the output register to
//   runs. one byte is accepted every cycle while the four-entry work queue
//   has room; the run emitter sends one result per cycle unless runs stalls,
//   and a byte giving a data run plus the closing run holds its queue entry for both.
// reset
//   frame closed, frame size zero, queue and output register empty.
// stall
//   when runs.ready is low the output register holds its item; the queue then
//   fills and stream.ready drops until the emitter drains an entry.
// ----------------------------------------------------------------------------
module rle_sprite_frame_decoder #(
    parameter int unsigned MAX_FRAME_PIXELS = rsfd_pkg::MAX_FRAME_PIXELS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rsfd_pkg::LEN_W-1:0] cfg_wr_data,
    rsfd_in_if.sink                    stream,
    rsfd_out_if.source                 runs
);

    rsfd_pkg::q_stat_t q_stat;
    rsfd_pkg::entry_t  push_entry;
    rsfd_pkg::entry_t  head;
    logic              push;
    logic              pop;

    rsfd_front #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stream      (stream),
        .q_stat      (q_stat),
        .push        (push),
        .push_entry  (push_entry)
    );

    rsfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    rsfd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .runs   (runs)
    );

endmodule

[test/rsfd_run_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfd_run_checker
// watches the byte and run channels and the frame size writes, works out the
// runs each accepted byte must cause and compares every accepted run with them
// ----------------------------------------------------------------------------
module rsfd_run_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rsfd_pkg::LEN_W-1:0] cfg_wr_data,
    rsfd_in_if                         stream,
    rsfd_out_if                        runs,
    output int                         fail_count,
    output int                         pending,
    output int                         bytes_seen,
    output int                         runs_seen,
    output int                         frames_seen,
    output int                         fill_runs
);

    localparam int PIXEL_W         = rsfd_pkg::PIXEL_W;
    localparam int LEN_W           = rsfd_pkg::LEN_W;
    localparam int COUNT_W         = rsfd_pkg::COUNT_W;
    localparam int REPEAT_FLAG_BIT = rsfd_pkg::REPEAT_FLAG_BIT;

    localparam logic [1:0] WAIT_CMD   = 2'd0;
    localparam logic [1:0] WAIT_VALUE = 2'd1;
    localparam logic [1:0] IN_LITERAL = 2'd2;
    localparam logic [1:0] FRAME_DONE = 2'd3;

    typedef struct packed {
        logic [PIXEL_W-1:0] value;
        logic [LEN_W-1:0]   len;
        logic               pad;
        logic               fend;
        logic               last;
    } run_t;

    localparam logic [LEN_W-1:0] SIZE_CAP = LEN_W'(rsfd_pkg::MAX_FRAME_PIXELS_DEF);

    run_t               expected_runs[$];
    logic [LEN_W-1:0]   frame_size;
    logic [1:0]         phase;
    logic [COUNT_W-1:0] lit_left;
    logic [COUNT_W-1:0] rep_count;
    logic [LEN_W-1:0]   owed;
    logic               frame_open;
    int                 mismatches;
    int                 n_bytes;
    int                 n_runs;
    int                 n_frames;
    int                 n_fill;

    task automatic report(input string msg);
        mismatches++;
        $display("chk: %0t run %0d: %s", $time, n_runs, msg);
    endtask

    task automatic decode_byte(input logic [PIXEL_W-1:0] b, input logic last_byte);
        run_t             data_run;
        run_t             close_run;
        logic             got_data;
        logic             got_close;
        logic [LEN_W-1:0] take;
        got_data  = 1'b0;
        got_close = 1'b0;
        data_run  = '0;
        close_run = '0;
        // size is sampled on the first byte of a frame
        if (!frame_open)
        begin
            owed       = (frame_size > SIZE_CAP) ? SIZE_CAP : frame_size;
            frame_open = 1'b1;
            lit_left   = '0;
            rep_count  = '0;
            phase      = (owed == 0) ? FRAME_DONE : WAIT_CMD;
        end
        case (phase)
            WAIT_CMD:
                // a command on the closing byte is dropped
                if (!last_byte)
                begin
                    if (b[REPEAT_FLAG_BIT])
                    begin
                        rep_count = b[COUNT_W-1:0];
                        phase     = WAIT_VALUE;
                    end
                    else
                    begin
                        lit_left = b[COUNT_W-1:0];
                        phase    = (b == 0) ? WAIT_CMD : IN_LITERAL;
                    end
                end
            WAIT_VALUE:
                // zero count is the end marker, its value byte is swallowed
                if (rep_count == 0)
                    phase = FRAME_DONE;
                else
                begin
                    take      = (LEN_W'(rep_count) > owed) ? owed : LEN_W'(rep_count);
                    data_run  = '{value: b, len: take, pad: 1'b0, fend: 1'b0, last: 1'b0};
                    got_data  = 1'b1;
                    owed      = owed - take;
                    rep_count = '0;
                    phase     = (owed == 0) ? FRAME_DONE : WAIT_CMD;
                end
            IN_LITERAL:
            begin
                data_run = '{value: b, len: LEN_W'(1), pad: 1'b0, fend: 1'b0, last: 1'b0};
                got_data = 1'b1;
                owed     = owed - 1'b1;
                lit_left = lit_left - 1'b1;
                if (owed == 0)
                    phase = FRAME_DONE;
                else
                    phase = (lit_left != 0) ? IN_LITERAL : WAIT_CMD;
            end
            default:
                ;
        endcase
        if (last_byte)
        begin
            close_run  = '{value: '0, len: owed, pad: (owed != 0), fend: 1'b1, last: 1'b1};
            got_close  = 1'b1;
            owed       = '0;
            frame_open = 1'b0;
            lit_left   = '0;
            rep_count  = '0;
            phase      = WAIT_CMD;
        end
        if (got_data)
        begin
            data_run.last = !got_close;
            expected_runs = {expected_runs, data_run};
        end
        if (got_close)
            expected_runs = {expected_runs, close_run};
    endtask

    task automatic check_run(input run_t want);
        if (runs.pix_index !== want.value)
            report($sformatf("pix_index expected %0h got %0h", want.value, runs.pix_index));
        if (runs.run_length !== want.len)
            report($sformatf("run_length expected %0d got %0d", want.len, runs.run_length));
        if (runs.is_padding !== want.pad)
            report($sformatf("is_padding expected %0b got %0b", want.pad, runs.is_padding));
        if (runs.frame_end !== want.fend)
            report($sformatf("frame_end expected %0b got %0b", want.fend, runs.frame_end));
        if (runs.item_last !== want.last)
            report($sformatf("item_last expected %0b got %0b", want.last, runs.item_last));
        if (want.fend)
            n_frames++;
        if (want.pad)
            n_fill++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_runs.delete();
            frame_size  = '0;
            phase       = WAIT_CMD;
            lit_left    = '0;
            rep_count   = '0;
            owed        = '0;
            frame_open  = 1'b0;
            mismatches  = 0;
            n_bytes     = 0;
            n_runs      = 0;
            n_frames    = 0;
            n_fill      = 0;
            fail_count  <= 0;
            pending     <= 0;
            bytes_seen  <= 0;
            runs_seen   <= 0;
            frames_seen <= 0;
            fill_runs   <= 0;
        end
        else
        begin
            if (runs.valid && runs.ready)
            begin
                n_runs++;
                if (expected_runs.size() == 0)
                    report($sformatf("unexpected run value %0h length %0d",
                                     runs.pix_index, runs.run_length));
                else
                    check_run(expected_runs.pop_front());
            end
            if (stream.valid && stream.ready)
            begin
                n_bytes++;
                decode_byte(stream.data_byte, stream.stream_end);
            end
            // a size written at this edge is seen from the next byte on
            if (cfg_wr_en)
                frame_size = cfg_wr_data;
            fail_count  <= mismatches;
            pending     <= expected_runs.size();
            bytes_seen  <= n_bytes;
            runs_seen   <= n_runs;
            frames_seen <= n_frames;
            fill_runs   <= n_fill;
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives compressed frames into the run-length decoder under several frame
// sizes, with random gaps on the byte side and random stalls on the run side
// ----------------------------------------------------------------------------
module tb;

    localparam int PIXEL_W = rsfd_pkg::PIXEL_W;
    localparam int LEN_W   = rsfd_pkg::LEN_W;

    localparam int HALF_PERIOD   = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int PHASE_BYTES   = 60;

    localparam logic [PIXEL_W-1:0] REPEAT_CMD   =
        PIXEL_W'(1 << rsfd_pkg::REPEAT_FLAG_BIT);
    localparam logic [PIXEL_W-1:0] END_MARKER   = REPEAT_CMD;
    localparam logic [PIXEL_W-1:0] LITERAL_NONE = '0;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [LEN_W-1:0]   cfg_wr_data;
    int                 fail_count;
    int                 pending;
    int                 bytes_seen;
    int                 runs_seen;
    int                 frames_seen;
    int                 fill_runs;
    logic               tx_calm;
    logic               rx_calm;
    int                 rx_hold;
    int                 quiet_cycles;
    int                 bytes_sent;
    logic [PIXEL_W-1:0] frame_bytes[$];
    logic [LEN_W-1:0]   sizes[$];

    rsfd_in_if  in_ch ();
    rsfd_out_if out_ch ();

    rle_sprite_frame_decoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stream      (in_ch),
        .runs        (out_ch)
    );

    rsfd_run_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stream      (in_ch),
        .runs        (out_ch),
        .fail_count  (fail_count),
        .pending     (pending),
        .bytes_seen  (bytes_seen),
        .runs_seen   (runs_seen),
        .frames_seen (frames_seen),
        .fill_runs   (fill_runs)
    );

    always #HALF_PERIOD clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_hold      <= 0;
        end
        else if (rx_hold > 0)
        begin
            out_ch.ready <= 1'b0;
            rx_hold      <= rx_hold - 1;
        end
        else if (!rx_calm && $urandom_range(0, 3) == 0)
        begin
            out_ch.ready <= 1'b0;
            rx_hold      <= pick_gap();
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_byte(input logic [PIXEL_W-1:0] b, input logic last_byte);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.stream_end <= last_byte;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [LEN_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly well-formed commands with random content, some noise, and now
    // and then a frame cut short in the middle of a command
    task automatic build_random_frame();
        int ntok;
        int kind;
        int cnt;
        int cut;
        frame_bytes.delete();
        ntok = $urandom_range(1, 8);
        repeat (ntok)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 8)
            begin
                cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 8);
                frame_bytes = {frame_bytes, REPEAT_CMD | PIXEL_W'(cnt)};
                frame_bytes = {frame_bytes, PIXEL_W'($urandom)};
            end
            else if (kind < 15)
            begin
                cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(32, 127)
                                                   : $urandom_range(1, 6);
                frame_bytes = {frame_bytes, PIXEL_W'(cnt)};
                repeat (cnt) frame_bytes = {frame_bytes, PIXEL_W'($urandom)};
            end
            else if (kind == 15)
                frame_bytes = {frame_bytes, LITERAL_NONE};
            else if (kind == 16)
            begin
                frame_bytes = {frame_bytes, END_MARKER};
                frame_bytes = {frame_bytes, PIXEL_W'($urandom)};
            end
            else
                frame_bytes = {frame_bytes, PIXEL_W'($urandom)};
        end
        if ($urandom_range(0, 3) == 0)
        begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
        else
            frame_bytes = {frame_bytes, PIXEL_W'($urandom)};
    endtask

    initial
    begin
        int  phase_start;
        bit  paused;
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.stream_end = 1'b0;
        tx_calm          = 1'b0;
        rx_calm          = 1'b0;
        bytes_sent       = 0;
        paused           = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_size(LEN_W'(20));
        // repeat run, literals, zero literal count, run clipped to the frame,
        // ignored byte once full, then the closing byte, also ignored
        frame_bytes = '{8'h83, 8'hFF, 8'h02, 8'h00, 8'hAA, 8'h00, 8'hFF, 8'h55,
                        8'h12, 8'h80};
        send_frame();
        // lone command on the closing byte, whole frame padded
        frame_bytes = '{8'h85};
        send_frame();
        // end marker, everything after it ignored
        frame_bytes = '{8'h80, 8'h33, 8'h01, 8'h44};
        send_frame();
        // literal byte and repeat value on the closing byte give two runs
        frame_bytes = '{8'h7F, 8'hC3};
        send_frame();
        frame_bytes = '{8'h81, 8'h9A};
        send_frame();

        // zero size: every byte ignored, empty closing run
        write_size('0);
        frame_bytes = '{8'h81, 8'h05, 8'h7F};
        send_frame();

        write_size(LEN_W'(1));
        frame_bytes = '{8'h01, 8'hE7, 8'h2A};
        send_frame();

        sizes = '{LEN_W'(rsfd_pkg::MAX_FRAME_PIXELS_DEF), '1, '0, LEN_W'(1),
                  LEN_W'($urandom_range(2, 300)), LEN_W'($urandom_range(2, 300)),
                  LEN_W'($urandom_range(300, 3000)), LEN_W'($urandom_range(2, 60))};
        for (int p = 0; p < sizes.size(); p++)
        begin
            write_size(sizes[p]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm <= ($urandom_range(0, 3) == 0);
                build_random_frame();
                send_frame();
                // hold the sender back once until the decoder has emptied
                if (p == 4 && !paused)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("tb: %0d bytes in, %0d runs checked over %0d frames, %0d zero-filled",
                 bytes_seen, runs_seen, frames_seen, fill_runs);
        $display("tb: frame sizes from zero up to past the cap, gaps and stalls on both sides");
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/rsfd_pkg.sv
rtl/rsfd_in_if.sv
rtl/rsfd_out_if.sv
rtl/rsfd_front.sv
rtl/rsfd_queue.sv
rtl/rsfd_back.sv
rtl/rle_sprite_frame_decoder.sv
test/rsfd_run_checker.sv
test/tb.sv
